FILE: src/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
package spq_pkg;

  localparam int CAPACITY    = 16;
  localparam int COUNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int DATA_W      = 32;
  localparam int PRIO_W      = 16;
  localparam int OCC_W       = 5;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } spq_status_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;  // capture the incoming operation
    logic exec;  // run the operation and load the result register
  } spq_cmd_t;

endpackage

FILE: src/spq_ctrl.sv
// Controller: input acceptance, operation sequencing and output valid.
module spq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output spq_pkg::spq_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign cmd.load = (state == S_IDLE) && in_valid;
  assign cmd.exec = (state == S_EXEC) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/spq_dp.sv
// Datapath: sorted compare-and-shift entry array, count and result register.
module spq_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  spq_pkg::spq_cmd_t                cmd,
  input  logic                             in_mode,
  input  logic signed [spq_pkg::DATA_W-1:0] in_data,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_prio,
  output spq_pkg::spq_status_t             res_status,
  output logic signed [spq_pkg::DATA_W-1:0] res_data,
  output logic signed [spq_pkg::PRIO_W-1:0] res_prio,
  output logic [spq_pkg::OCC_W-1:0]        res_occ
);

  localparam int CAP = spq_pkg::CAPACITY;
  localparam int CW  = spq_pkg::COUNT_W;

  logic                             op_mode;
  logic signed [spq_pkg::DATA_W-1:0] op_data;
  logic signed [spq_pkg::PRIO_W-1:0] op_prio;

  logic signed [spq_pkg::DATA_W-1:0] entry_data [CAP];
  logic signed [spq_pkg::PRIO_W-1:0] entry_prio [CAP];
  logic [CW-1:0]                    count;
  logic [CW-1:0]                    count_next;
  logic [CAP-1:0]                   gt;
  logic                             full;
  logic                             empty;
  logic                             do_ins;
  logic                             do_del;
  logic [CW+spq_pkg::OCC_W-1:0]     occ_wide;

  assign full   = (count == CW'(CAP));
  assign empty  = (count == '0);
  assign do_ins = cmd.exec && (op_mode == spq_pkg::MODE_INSERT) && !full;
  assign do_del = cmd.exec && (op_mode == spq_pkg::MODE_DELETE) && !empty;

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CW'(1);
    end else if (do_del) begin
      count_next = count - CW'(1);
    end
  end

  assign occ_wide = {{spq_pkg::OCC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode <= in_mode;
      op_data <= in_data;
      op_prio <= in_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Each cell compares against the new priority; the "greater" cells form a prefix.
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    assign gt[i] = (CW'(i) < count) && (entry_prio[i] > op_prio);

    always_ff @(posedge clk) begin
      if (do_ins && !gt[i]) begin
        if (i == 0) begin
          entry_data[i] <= op_data;
          entry_prio[i] <= op_prio;
        end else if (gt[(i == 0) ? 0 : i-1]) begin
          entry_data[i] <= op_data;
          entry_prio[i] <= op_prio;
        end else begin
          entry_data[i] <= entry_data[(i == 0) ? 0 : i-1];
          entry_prio[i] <= entry_prio[(i == 0) ? 0 : i-1];
        end
      end else if (do_del && (i < CAP - 1)) begin
        entry_data[i] <= entry_data[(i < CAP - 1) ? i+1 : i];
        entry_prio[i] <= entry_prio[(i < CAP - 1) ? i+1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_data   <= '0;
      res_prio   <= '0;
      res_status <= spq_pkg::ST_OK;
      res_occ    <= occ_wide[spq_pkg::OCC_W-1:0];
      if (op_mode == spq_pkg::MODE_INSERT) begin
        if (full) begin
          res_status <= spq_pkg::ST_OVERFLOW;
        end
      end else if (empty) begin
        res_status <= spq_pkg::ST_UNDERFLOW;
      end else begin
        res_data <= entry_data[0];
        res_prio <= entry_prio[0];
      end
    end
  end

endmodule

FILE: src/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: stream ports, controller and datapath.
// Sequence: an input transfer is captured into the operation register, then the
//   execute step loads the result register and raises the result valid; a stalled
//   output holds the execute step. A new operation is taken only after the execute step.
// Reset (rst, synchronous, active high) empties the queue, clears the result valid
//   and idles the controller; entry contents are left as they are and are never
//   read before being written.
module sorted_priority_queue_core (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream. tdata: data_word [31:0], priority_req [47:32]. tuser: mode [0].
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [spq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic [0:0]                         s_axis_tuser,
  // Result stream. tdata: out_data [31:0], out_priority [47:32], occupancy [52:48],
  // zeros [55:53]. tuser: status [1:0].
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [spq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic [1:0]                         m_axis_tuser
);

  spq_pkg::spq_cmd_t                 cmd;
  spq_pkg::spq_status_t              res_status;
  logic signed [spq_pkg::DATA_W-1:0] res_data;
  logic signed [spq_pkg::PRIO_W-1:0] res_prio;
  logic [spq_pkg::OCC_W-1:0]         res_occ;

  // Sequencer: takes one transfer, runs it, and waits on a full result register.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  // Sorted entry array: insert shifts the tail of lower or equal priority down one cell,
  // delete shifts everything up one cell and returns the head.
  spq_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_mode    (s_axis_tuser[0]),
    .in_data    (s_axis_tdata[31:0]),
    .in_prio    (s_axis_tdata[47:32]),
    .res_status (res_status),
    .res_data   (res_data),
    .res_prio   (res_prio),
    .res_occ    (res_occ)
  );

  assign m_axis_tdata = {3'b000, res_occ, res_prio, res_data};
  assign m_axis_tuser = res_status;

endmodule

FILE: src/spq_checker.sv
// Port-level checker of the sorted priority queue, bound to the top level.
module spq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [spq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                      m_axis_tuser
);

  localparam logic [4:0] CAP5 = 5'(spq_pkg::CAPACITY);

  // A stalled result transfer stays offered and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Underflow reports an empty queue and no payload.
  a_underflow: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == 2'(spq_pkg::ST_UNDERFLOW)) |->
      (m_axis_tdata == '0))
    else $error("underflow result not all zero");

  // Overflow only when full, with no payload.
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == 2'(spq_pkg::ST_OVERFLOW)) |->
      (m_axis_tdata[52:48] == CAP5) && (m_axis_tdata[47:0] == '0))
    else $error("overflow result inconsistent");

  // No status code beyond overflow.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("unknown status code");

  // After an input transfer, ready drops while the operation executes.
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an operation was in flight");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);

FILE: verif/spq_check_pkg.sv
// Expected-result model and result checker for the sorted priority queue bench.
`timescale 1ns / 1ps
package spq_check_pkg;

  typedef struct {
    spq_pkg::spq_status_t status;
    logic [31:0] data;
    logic [15:0] prio;
    logic [4:0]  occ;
  } spq_result_t;

  class spq_scoreboard;
    logic [31:0]        held_data [spq_pkg::CAPACITY];
    logic signed [15:0] held_prio [spq_pkg::CAPACITY];
    int                 held_count = 0;
    spq_result_t        awaited [$];
    int                 errors = 0;

    // Apply one accepted operation to the mirror queue; queue its result.
    function void note_op(logic mode, logic [31:0] word, logic signed [15:0] prio);
      spq_result_t res;
      int pos;
      int i;
      res = '{spq_pkg::ST_OK, 32'd0, 16'd0, 5'd0};
      if (mode == spq_pkg::MODE_INSERT) begin
        if (held_count >= spq_pkg::CAPACITY) begin
          res.status = spq_pkg::ST_OVERFLOW;
        end else begin
          // ties go in front: newest of equal priority is served first
          pos = 0;
          while (pos < held_count && held_prio[pos] > prio) pos++;
          for (i = held_count; i > pos; i--) begin
            held_data[i] = held_data[i - 1];
            held_prio[i] = held_prio[i - 1];
          end
          held_data[pos] = word;
          held_prio[pos] = prio;
          held_count++;
        end
      end else begin
        if (held_count == 0) begin
          res.status = spq_pkg::ST_UNDERFLOW;
        end else begin
          res.data = held_data[0];
          res.prio = held_prio[0];
          for (i = 1; i < held_count; i++) begin
            held_data[i - 1] = held_data[i];
            held_prio[i - 1] = held_prio[i];
          end
          held_count--;
        end
      end
      res.occ = held_count[4:0];
      awaited.push_back(res);
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void check_result(logic [1:0] status, logic [31:0] data, logic [15:0] prio,
                               logic [4:0] occ);
      spq_result_t exp_res;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: status %0d data %h", status, data);
        errors++;
        return;
      end
      exp_res = awaited.pop_front();
      if (status !== exp_res.status) begin
        $error("status: expected %0d, actual %0d", exp_res.status, status);
        errors++;
      end
      if (data !== exp_res.data) begin
        $error("out_data: expected %h, actual %h", exp_res.data, data);
        errors++;
      end
      if (prio !== exp_res.prio) begin
        $error("out_priority: expected %0d, actual %0d",
               $signed(exp_res.prio), $signed(prio));
        errors++;
      end
      if (occ !== exp_res.occ) begin
        $error("occupancy: expected %0d, actual %0d", exp_res.occ, occ);
        errors++;
      end
    endfunction
  endclass

endpackage

FILE: verif/sorted_priority_queue_core_test.sv
// Self-checking stream bench for the sorted priority queue core.
`timescale 1ns / 1ps
module sorted_priority_queue_core_test;

  localparam int RANDOM_OPS  = 650;
  localparam int CYCLE_LIMIT = 200000;  // far above the slowest plausible run

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [spq_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]                      s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [spq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]                      m_axis_tuser;

  bit                           no_idle = 1'b0;  // when set, neither side inserts bubbles
  int                           cycles = 0;
  spq_check_pkg::spq_scoreboard sb;

  sorted_priority_queue_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sorted_priority_queue_core_test: done, errors");
      $finish;
    end
  end

  // Result side. Handshake signals are read as they stood before the edge,
  // so a transfer seen here is exactly the one the core saw.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[47:32],
                      m_axis_tdata[52:48]);
    end
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 24);
  end

  // One operation: optional bubbles, then hold valid until the transfer.
  // Valid stays high across back-to-back transfers; in this task it only drops for a bubble.
  task automatic send_op(input logic mode, input logic [31:0] word, input logic [15:0] prio);
    while (!no_idle && $urandom_range(0, 99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid   <= 1'b1;
    s_axis_tdata    <= {prio, word};
    s_axis_tuser[0] <= mode;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_op(mode, word, prio);
  endtask

  // Mostly full-range priorities, with a share of narrow ones to force ties
  // and some at the two extremes.
  function automatic logic [15:0] pick_prio();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
    if (r <= 3) return 16'($signed($urandom_range(0, 6)) - 3);
    return 16'($urandom);
  endfunction

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int seg_len;
    int ins_pct;
    int k;
    sb = new;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: delete from empty queue -> underflow.
    send_op(spq_pkg::MODE_DELETE, 32'hffffffff, 16'hffff);
    // Payload and priority extremes, ties at zero and at the top.
    send_op(spq_pkg::MODE_INSERT, 32'h7fffffff, 16'h0000);
    send_op(spq_pkg::MODE_INSERT, 32'h80000000, 16'h7fff);
    send_op(spq_pkg::MODE_INSERT, 32'h00000000, 16'h8000);
    send_op(spq_pkg::MODE_INSERT, 32'hffffffff, 16'h0000);
    send_op(spq_pkg::MODE_INSERT, 32'h5a5a5a5a, 16'hffff);
    send_op(spq_pkg::MODE_INSERT, 32'ha5a5a5a5, 16'h0001);
    send_op(spq_pkg::MODE_INSERT, 32'h00000001, 16'h7fff);
    // Fill to capacity, then one insert into a full queue -> overflow.
    for (k = 0; k < spq_pkg::CAPACITY - 7; k++) begin
      send_op(spq_pkg::MODE_INSERT, 32'h11111111 * (k + 1), 16'($signed(k % 5) - 2));
    end
    send_op(spq_pkg::MODE_INSERT, 32'hdeadbeef, 16'h7fff);
    send_op(spq_pkg::MODE_DELETE, 32'h0, 16'h0);
    send_op(spq_pkg::MODE_DELETE, 32'h0, 16'h0);
    send_op(spq_pkg::MODE_DELETE, 32'h0, 16'h0);

    // Hold off the sender until the queue has answered everything.
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // Random: segments biased to fill, to drain, or mixed, so the queue keeps
    // swinging between empty and full. A middle stretch runs without bubbles.
    sent = 0;
    while (sent < RANDOM_OPS) begin
      seg_len = $urandom_range(20, 50);
      case ($urandom_range(0, 2))
        0:       ins_pct = 80;
        1:       ins_pct = 20;
        default: ins_pct = 55;
      endcase
      for (k = 0; k < seg_len && sent < RANDOM_OPS; k++) begin
        no_idle = (sent >= 250 && sent < 400);
        send_op(($urandom_range(0, 99) < ins_pct) ? spq_pkg::MODE_INSERT
                                                  : spq_pkg::MODE_DELETE,
                $urandom, pick_prio());
        sent++;
      end
    end
    no_idle = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain, then give any stray result time to show up.
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("sorted_priority_queue_core_test: done, clean");
    end else begin
      $display("sorted_priority_queue_core_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: sorted_priority_queue_core.f
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_dp.sv
src/sorted_priority_queue_core.sv
src/spq_checker.sv
verif/spq_check_pkg.sv
verif/sorted_priority_queue_core_test.sv
